FILE: src/assert_macros.svh
// Assertion helpers shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMP(lbl, clk, rst_n, a, b) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
		else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(lbl, clk, rst_n, a, b) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
		else $error("assertion failed");

`endif

FILE: src/mbc_pkg.sv
package mbc_pkg;

	localparam int NumRounds = 32;
	localparam int RotAmount = 11;
	localparam int NumKeyWords = 8;

	typedef logic [31:0] word_t;
	typedef logic [63:0] block_t;

	// Configuration register indexes
	typedef enum logic [2:0] {
		REG_KEY01 = 3'd0,
		REG_KEY23 = 3'd1,
		REG_KEY45 = 3'd2,
		REG_KEY67 = 3'd3,
		REG_DIR   = 3'd4
	} reg_idx_t;

	// S-boxes, one per nibble, nibble 0 is the least significant
	localparam logic [3:0] SBOX [8][16] = '{
		'{4'd12, 4'd4, 4'd6, 4'd2, 4'd10, 4'd5, 4'd11, 4'd9,
		  4'd14, 4'd8, 4'd13, 4'd7, 4'd0, 4'd3, 4'd15, 4'd1},
		'{4'd6, 4'd8, 4'd2, 4'd3, 4'd9, 4'd10, 4'd5, 4'd12,
		  4'd1, 4'd14, 4'd4, 4'd7, 4'd11, 4'd13, 4'd0, 4'd15},
		'{4'd11, 4'd3, 4'd5, 4'd8, 4'd2, 4'd15, 4'd10, 4'd13,
		  4'd14, 4'd1, 4'd7, 4'd4, 4'd12, 4'd9, 4'd6, 4'd0},
		'{4'd12, 4'd8, 4'd2, 4'd1, 4'd13, 4'd4, 4'd15, 4'd6,
		  4'd7, 4'd0, 4'd10, 4'd5, 4'd3, 4'd14, 4'd9, 4'd11},
		'{4'd7, 4'd15, 4'd5, 4'd10, 4'd8, 4'd1, 4'd6, 4'd13,
		  4'd0, 4'd9, 4'd3, 4'd14, 4'd11, 4'd4, 4'd2, 4'd12},
		'{4'd5, 4'd13, 4'd15, 4'd6, 4'd9, 4'd2, 4'd12, 4'd10,
		  4'd11, 4'd7, 4'd8, 4'd1, 4'd4, 4'd3, 4'd14, 4'd0},
		'{4'd8, 4'd14, 4'd2, 4'd5, 4'd6, 4'd9, 4'd1, 4'd12,
		  4'd15, 4'd4, 4'd11, 4'd0, 4'd13, 4'd10, 4'd3, 4'd7},
		'{4'd1, 4'd7, 4'd14, 4'd13, 4'd0, 4'd5, 4'd8, 4'd3,
		  4'd4, 4'd15, 4'd10, 4'd6, 4'd9, 4'd12, 4'd11, 4'd2}
	};

	// Nibble-wise substitution
	function automatic word_t substitute(input word_t x);
		word_t y;
		y = '0;
		for (int i = 0; i < 8; i++) begin
			y[4*i +: 4] = SBOX[i][x[4*i +: 4]];
		end
		return y;
	endfunction

	// Round function: add key, substitute, rotate left
	function automatic word_t round_fn(input word_t a, input word_t k);
		word_t t;
		t = substitute(a + k);
		return {t[31-RotAmount:0], t[31:32-RotAmount]};
	endfunction

	// Key word used in round r; decrypt runs the schedule backwards
	function automatic logic [2:0] key_sel(input int r, input logic dec);
		int idx;
		idx = dec ? (NumRounds - 1 - r) : r;
		if (idx < 24) begin
			return 3'(idx % NumKeyWords);
		end
		return 3'(NumRounds - 1 - idx);
	endfunction

endpackage

FILE: src/magma_block_cipher.sv
// Channel   | Signals                          | Word
// ----------+----------------------------------+-----------------------------
// s_axis    | tvalid, tready, tdata[63:0]      | input block
// m_axis    | tvalid, tready, tdata[63:0]      | processed block
// config    | wr_en, wr_addr[2:0], wr_data     | key pairs 0..3, direction 4
//
// Chain of 32 round cells, one round per cell; one block per cycle sustained
// while m_axis is not stalled. The last cell's register is the output register.
// Each cell holds its word when the next one is full and stalled; s_axis
// tready drops only when the whole chain is full and m_axis is stalled.
// Reset clears the key, the direction and every cell's valid bit.
`include "assert_macros.svh"

module magma_block_cipher (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [63:0] s_axis_tdata,   // [63:0] block_in
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [63:0] m_axis_tdata,   // [63:0] block_out
	input  logic        wr_en,
	input  logic [2:0]  wr_addr,
	input  logic [63:0] wr_data
);
	import mbc_pkg::*;

	word_t  round_keys [NumRounds];
	logic   vld [NumRounds+1];
	logic   rdy [NumRounds+1];
	block_t dat [NumRounds+1];

	mbc_key_regs u_keys (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr_en     (wr_en),
		.wr_addr   (wr_addr),
		.wr_data   (wr_data),
		.round_keys(round_keys)
	);

	assign vld[0] = s_axis_tvalid;
	assign dat[0] = s_axis_tdata;
	assign s_axis_tready = rdy[0];

	// round cells
	for (genvar r = 0; r < NumRounds; r++) begin : g_cell
		mbc_round_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.in_valid (vld[r]),
			.in_ready (rdy[r]),
			.in_data  (dat[r]),
			.rkey     (round_keys[r]),
			.out_valid(vld[r+1]),
			.out_ready(rdy[r+1]),
			.out_data (dat[r+1])
		);
	end

	// last round does not swap: undo the cell's swap
	assign rdy[NumRounds] = m_axis_tready;
	assign m_axis_tvalid  = vld[NumRounds];
	assign m_axis_tdata   = {dat[NumRounds][31:0], dat[NumRounds][63:32]};

	`ASSERT_IMP(a_backpressure, clk, arst_n, !s_axis_tready, m_axis_tvalid && !m_axis_tready)

endmodule

FILE: src/mbc_key_regs.sv
`include "assert_macros.svh"

module mbc_key_regs (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 wr_en,
	input  logic [2:0]           wr_addr,
	input  logic [63:0]          wr_data,
	output mbc_pkg::word_t       round_keys [mbc_pkg::NumRounds]
);
	import mbc_pkg::*;

	block_t key_q [4];
	logic   dir_q;
	word_t  kw [NumKeyWords];

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 4; i++) key_q[i] <= '0;
			dir_q <= 1'b0;
		end else if (wr_en) begin
			case (wr_addr)
				REG_KEY01: key_q[0] <= wr_data;
				REG_KEY23: key_q[1] <= wr_data;
				REG_KEY45: key_q[2] <= wr_data;
				REG_KEY67: key_q[3] <= wr_data;
				REG_DIR:   dir_q <= wr_data[0];
				default: ;
			endcase
		end
	end

	// split into K1..K8, K1 is the upper half of the first register
	always_comb begin
		for (int i = 0; i < NumKeyWords; i++) begin
			kw[i] = (i % 2 == 0) ? key_q[i/2][63:32] : key_q[i/2][31:0];
		end
	end

	// per-round key mux, selected by round index and direction
	always_comb begin
		for (int r = 0; r < NumRounds; r++) begin
			round_keys[r] = kw[key_sel(r, dir_q)];
		end
	end

	`ASSERT_NEXT(a_dir_write, clk, arst_n, wr_en && wr_addr == REG_DIR, dir_q == $past(wr_data[0]))

endmodule

FILE: src/mbc_round_cell.sv
`include "assert_macros.svh"

module mbc_round_cell (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  mbc_pkg::block_t in_data,
	input  mbc_pkg::word_t  rkey,
	output logic           out_valid,
	input  logic           out_ready,
	output mbc_pkg::block_t out_data
);
	import mbc_pkg::*;

	logic   v_q;
	block_t d_q;
	word_t  f;

	// stage takes a word when empty or when its word moves on
	assign in_ready = !v_q || out_ready;
	assign f = round_fn(in_data[31:0], rkey);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (in_ready) begin
			v_q <= in_valid;
		end
	end

	// one round with swap: new upper = a0, new lower = f ^ a1
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			d_q <= {in_data[31:0], f ^ in_data[63:32]};
		end
	end

	assign out_valid = v_q;
	assign out_data  = d_q;

	`ASSERT_NEXT(a_hold, clk, arst_n, v_q && !out_ready, v_q && $stable(d_q))

endmodule
